// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define CDA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("calendar_date_advance: assertion failed");

// Condition in one cycle implies consequence in the next cycle.
`define CDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar_date_advance: assertion failed");

`else

`define CDA_ASSERT(label, clk, rst_n, prop)
`define CDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg
// Widths, calendar constants, state codes and shared types of the date unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

    localparam int YEAR_BITS  = 14;
    localparam int COUNT_BITS = 16;
    localparam int DAY_BITS   = 5;
    localparam int MONTH_BITS = 4;

    // Width used when the day count is compared with a day distance.
    localparam int CMP_BITS = (COUNT_BITS > 6) ? COUNT_BITS : 6;

    // The year remainder by 400 is year - 400 * floor((year >> 4) / 25). The
    // division by 25 is a multiply by the rounded-up reciprocal 2^RCP_SHIFT / 25
    // followed by a shift; with RCP_SHIFT = YEAR_BITS + 1 the quotient is exact
    // for every year that fits in YEAR_BITS.
    localparam int YHI_BITS  = YEAR_BITS - 4;
    localparam int RCP_SHIFT = YEAR_BITS + 1;
    localparam int RCP_BITS  = YEAR_BITS - 3;
    localparam int PROD_BITS = YHI_BITS + RCP_BITS;
    localparam int QUOT_BITS = YEAR_BITS - 8;
    localparam longint unsigned RCP_25 = ((64'd1 << RCP_SHIFT) + 64'd24) / 64'd25;

    // Steps the remainder unit takes after a start: quotient, then remainder.
    localparam int MOD_CNT_BITS = 2;
    localparam logic [MOD_CNT_BITS-1:0] MOD_STEPS = 2'd2;

    // Year modulo 400 fits in 9 bits.
    localparam int R400_BITS = 9;

    // Stream payload layout.
    localparam int IN_FIELD_BITS  = DAY_BITS + MONTH_BITS + YEAR_BITS + COUNT_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = DAY_BITS + MONTH_BITS + YEAR_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS  = 2;

    localparam int MONTH_LO = DAY_BITS;
    localparam int YEAR_LO  = DAY_BITS + MONTH_BITS;
    localparam int COUNT_LO = DAY_BITS + MONTH_BITS + YEAR_BITS;

    localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

    localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_BITS-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_BITS-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_BITS-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_BITS-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_BITS-1:0] DAYS_31   = 5'd31;
    localparam logic [DAY_BITS-1:0] DAYS_30   = 5'd30;
    localparam logic [DAY_BITS-1:0] DAYS_29   = 5'd29;
    localparam logic [DAY_BITS-1:0] DAYS_28   = 5'd28;
    localparam logic [DAY_BITS-1:0] FIRST_DAY = 5'd1;

    localparam logic [R400_BITS-1:0] CYCLE_400  = 9'd400;
    localparam logic [R400_BITS-1:0] CYCLE_LAST = 9'd399;
    localparam logic [R400_BITS-1:0] CENT_1     = 9'd100;
    localparam logic [R400_BITS-1:0] CENT_2     = 9'd200;
    localparam logic [R400_BITS-1:0] CENT_3     = 9'd300;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MOD   = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_STEP  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    // Commands to the year remainder unit.
    typedef struct packed {
        logic start;
        logic incr;
    } mod_ctrl_t;

    // Status of the year remainder unit.
    typedef struct packed {
        logic                 busy;
        logic                 leap;
        logic [R400_BITS-1:0] r400;
    } mod_stat_t;

    // Result of one month step evaluation.
    typedef struct packed {
        logic                 day_ok;
        logic                 fits;
        logic [DAY_BITS-1:0]  next_day;
        logic [CMP_BITS-1:0]  rem_after;
    } mstep_t;

endpackage

`default_nettype wire

// ===== rtl/cda_year_mod400.sv =====
// ----------------------------------------------------------------------------
// cda_year_mod400
// Remainder of the year by 400, kept current as the year advances.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_year_mod400 (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire cda_pkg::mod_ctrl_t            ctrl,
    input  wire logic [cda_pkg::YEAR_BITS-1:0] year,
    output cda_pkg::mod_stat_t                 stat
);

    logic [cda_pkg::QUOT_BITS-1:0]    quot_reg, quot_next;
    logic [cda_pkg::R400_BITS-1:0]    rem_reg, rem_next;
    logic [cda_pkg::MOD_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [cda_pkg::PROD_BITS-1:0]    prod;
    logic [cda_pkg::YEAR_BITS-1:0]    diff;

    // The year input holds still from the start until the remainder is formed.
    assign prod = cda_pkg::PROD_BITS'(year[cda_pkg::YEAR_BITS-1:4])
                  * cda_pkg::PROD_BITS'(cda_pkg::RCP_25);
    assign diff = year - cda_pkg::YEAR_BITS'(quot_reg)
                         * cda_pkg::YEAR_BITS'(cda_pkg::CYCLE_400);

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (ctrl.start) begin
            cnt_next = cda_pkg::MOD_STEPS;
        end else if (cnt_reg == cda_pkg::MOD_STEPS) begin
            quot_next = prod[cda_pkg::RCP_SHIFT +: cda_pkg::QUOT_BITS];
            cnt_next  = cnt_reg - cda_pkg::MOD_CNT_BITS'(1);
        end else if (cnt_reg != '0) begin
            rem_next = diff[cda_pkg::R400_BITS-1:0];
            cnt_next = cnt_reg - cda_pkg::MOD_CNT_BITS'(1);
        end else if (ctrl.incr) begin
            rem_next = (rem_reg == cda_pkg::CYCLE_LAST) ? '0
                                                        : rem_reg + cda_pkg::R400_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            cnt_reg <= '0;
        end else begin
            rem_reg <= rem_next;
            cnt_reg <= cnt_next;
        end
        quot_reg <= quot_next;
    end

    // Since 400 is a multiple of 4 and 100, the remainder alone decides leap years.
    assign stat.busy = (cnt_reg != '0);
    assign stat.r400 = rem_reg;
    assign stat.leap = (rem_reg[1:0] == 2'b00) && (rem_reg != cda_pkg::CENT_1)
                       && (rem_reg != cda_pkg::CENT_2) && (rem_reg != cda_pkg::CENT_3);

endmodule

`default_nettype wire

// ===== rtl/cda_month_unit.sv =====
// ----------------------------------------------------------------------------
// cda_month_unit
// Shared month arithmetic: month length, day check and one month step.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_month_unit (
    input  wire logic [cda_pkg::DAY_BITS-1:0]   day,
    input  wire logic [cda_pkg::MONTH_BITS-1:0] month,
    input  wire logic                           leap,
    input  wire logic [cda_pkg::COUNT_BITS-1:0] rem,
    output cda_pkg::mstep_t                     step
);

    logic [cda_pkg::DAY_BITS-1:0] mlen;
    logic [cda_pkg::CMP_BITS-1:0] to_next;
    logic [cda_pkg::CMP_BITS-1:0] rem_ext;
    logic [cda_pkg::CMP_BITS-1:0] day_sum;

    always_comb begin
        case (month)
            cda_pkg::MONTH_FEB: mlen = leap ? cda_pkg::DAYS_29 : cda_pkg::DAYS_28;
            cda_pkg::MONTH_APR,
            cda_pkg::MONTH_JUN,
            cda_pkg::MONTH_SEP,
            cda_pkg::MONTH_NOV: mlen = cda_pkg::DAYS_30;
            default:            mlen = cda_pkg::DAYS_31;
        endcase
    end

    // Days from the current day to the first of the next month, inclusive of today.
    assign to_next = cda_pkg::CMP_BITS'(mlen) - cda_pkg::CMP_BITS'(day)
                     + cda_pkg::CMP_BITS'(1);
    assign rem_ext = cda_pkg::CMP_BITS'(rem);
    assign day_sum = cda_pkg::CMP_BITS'(day) + rem_ext;

    assign step.day_ok    = (day != '0) && (day <= mlen);
    assign step.fits      = (rem_ext < to_next);
    assign step.next_day  = day_sum[cda_pkg::DAY_BITS-1:0];
    assign step.rem_after = rem_ext - to_next;

endmodule

`default_nettype wire

// ===== rtl/calendar_date_advance.sv =====
// ----------------------------------------------------------------------------
// calendar_date_advance
// Gregorian date validation and advance by a day count.
// ----------------------------------------------------------------------------
// Each input beat carries a date and a day count; one result beat comes back
// per input beat. The sequencer first forms the year modulo 400 (a
// reciprocal multiply for the quotient, then a subtract), checks the date,
// then moves forward one month boundary per cycle through a shared month
// unit, and finally holds the result until it is taken. s_axis_tready is
// high only while idle, so the next beat is taken only once the result beat
// has left. A full 16-bit count crosses about 2155 month boundaries. An
// invalid date returns unchanged with date_valid low; running past
// 31 December of the largest year stops there with year_overflow high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module calendar_date_advance (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // start_day, start_month, start_year, days_to_add; zero padded
    input  wire logic [cda_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // end_day, end_month, end_year; zero padded
    output logic [cda_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,
    // date_valid, year_overflow
    output logic [cda_pkg::OUT_USER_BITS-1:0]      m_axis_tuser
);

    cda_pkg::state_t state_reg, state_next;

    logic [cda_pkg::DAY_BITS-1:0]   day_reg, day_next;
    logic [cda_pkg::MONTH_BITS-1:0] month_reg, month_next;
    logic [cda_pkg::YEAR_BITS-1:0]  year_reg, year_next;
    logic [cda_pkg::COUNT_BITS-1:0] rem_reg, rem_next;
    logic                           valid_reg, valid_next;
    logic                           ovf_reg, ovf_next;

    cda_pkg::mod_ctrl_t mod_ctrl;
    cda_pkg::mod_stat_t mod_stat;
    cda_pkg::mstep_t    mstep;

    logic in_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    cda_year_mod400 u_mod400 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mod_ctrl),
        .year    (year_reg),
        .stat    (mod_stat)
    );

    cda_month_unit u_month (
        .day   (day_reg),
        .month (month_reg),
        .leap  (mod_stat.leap),
        .rem   (rem_reg),
        .step  (mstep)
    );

    always_comb begin
        state_next    = state_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        rem_next      = rem_reg;
        valid_next    = valid_reg;
        ovf_next      = ovf_reg;
        mod_ctrl      = '0;
        case (state_reg)
            cda_pkg::ST_IDLE: begin
                if (in_beat) begin
                    day_next       = s_axis_tdata[cda_pkg::DAY_BITS-1:0];
                    month_next     = s_axis_tdata[cda_pkg::MONTH_LO +: cda_pkg::MONTH_BITS];
                    year_next      = s_axis_tdata[cda_pkg::YEAR_LO +: cda_pkg::YEAR_BITS];
                    rem_next       = s_axis_tdata[cda_pkg::COUNT_LO +: cda_pkg::COUNT_BITS];
                    valid_next     = 1'b0;
                    ovf_next       = 1'b0;
                    mod_ctrl.start = 1'b1;
                    state_next     = cda_pkg::ST_MOD;
                end
            end
            cda_pkg::ST_MOD: begin
                if (!mod_stat.busy) begin
                    state_next = cda_pkg::ST_CHECK;
                end
            end
            cda_pkg::ST_CHECK: begin
                if ((month_reg >= cda_pkg::MONTH_JAN) && (month_reg <= cda_pkg::MONTH_DEC)
                    && (year_reg != '0) && mstep.day_ok) begin
                    valid_next = 1'b1;
                    state_next = cda_pkg::ST_STEP;
                end else begin
                    state_next = cda_pkg::ST_DONE;
                end
            end
            cda_pkg::ST_STEP: begin
                if (rem_reg == '0) begin
                    state_next = cda_pkg::ST_DONE;
                end else if (mstep.fits) begin
                    day_next   = mstep.next_day;
                    rem_next   = '0;
                    state_next = cda_pkg::ST_DONE;
                end else if ((month_reg == cda_pkg::MONTH_DEC) &&
                             (year_reg == cda_pkg::YEAR_MAX)) begin
                    day_next   = cda_pkg::DAYS_31;
                    ovf_next   = 1'b1;
                    rem_next   = '0;
                    state_next = cda_pkg::ST_DONE;
                end else begin
                    rem_next = mstep.rem_after[cda_pkg::COUNT_BITS-1:0];
                    day_next = cda_pkg::FIRST_DAY;
                    if (month_reg == cda_pkg::MONTH_DEC) begin
                        month_next    = cda_pkg::MONTH_JAN;
                        year_next     = year_reg + cda_pkg::YEAR_BITS'(1);
                        mod_ctrl.incr = 1'b1;
                    end else begin
                        month_next = month_reg + cda_pkg::MONTH_BITS'(1);
                    end
                end
            end
            cda_pkg::ST_DONE: begin
                if (m_axis_tready) begin
                    state_next = cda_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cda_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        rem_reg   <= rem_next;
        valid_reg <= valid_next;
        ovf_reg   <= ovf_next;
    end

    assign s_axis_tready = (state_reg == cda_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == cda_pkg::ST_DONE);
    assign m_axis_tdata  = cda_pkg::OUT_DATA_BITS'({year_reg, month_reg, day_reg});
    assign m_axis_tuser  = {ovf_reg, valid_reg};

    // The block never takes a new beat while a result is still pending.
    `CDA_ASSERT(a_no_overlap, aclk, aresetn, !(s_axis_tready && m_axis_tvalid))
    // Every month step strictly consumes part of the remaining count.
    `CDA_ASSERT_NEXT(a_rem_shrinks, aclk, aresetn,
        (state_reg == cda_pkg::ST_STEP) && (rem_reg != '0), rem_reg < $past(rem_reg))
    // While stepping, the working date stays a real calendar date.
    `CDA_ASSERT(a_step_date, aclk, aresetn,
        (state_reg != cda_pkg::ST_STEP) || ((month_reg >= cda_pkg::MONTH_JAN) &&
        (month_reg <= cda_pkg::MONTH_DEC) && (day_reg != '0) && (year_reg != '0)))
    // Overflow can only be reported for a valid starting date.
    `CDA_ASSERT(a_ovf_valid, aclk, aresetn, !(m_axis_tvalid && ovf_reg && !valid_reg))
    // The year remainder stays below 400.
    `CDA_ASSERT(a_r400_range, aclk, aresetn, mod_stat.r400 < cda_pkg::CYCLE_400)

endmodule

`default_nettype wire

// ===== tb/cda_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_checker
// Watches both stream channels of the date unit, predicts each result beat
// from the accepted input beat and compares every field in arrival order.
// ----------------------------------------------------------------------------
module cda_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    // start_day, start_month, start_year, days_to_add; zero padded
    input  wire logic [cda_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // end_day, end_month, end_year; zero padded
    input  wire logic [cda_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    // date_valid, year_overflow
    input  wire logic [cda_pkg::OUT_USER_BITS-1:0] m_axis_tuser,
    input  wire logic                              end_check,
    output int                                     fail_count,
    output int                                     pending
);
    import cda_pkg::*;

    typedef struct {
        logic [IN_DATA_BITS-1:0] src;
        logic [DAY_BITS-1:0]     day;
        logic [MONTH_BITS-1:0]   month;
        logic [YEAR_BITS-1:0]    year;
        logic                    valid;
        logic                    ovf;
    } date_out_t;

    date_out_t expected_dates[$];
    date_out_t want;
    bit        leftover_reported = 1'b0;

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        if (m == MONTH_FEB) begin
            return leap ? DAYS_29 : DAYS_28;
        end
        if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
            return DAYS_30;
        end
        return DAYS_31;
    endfunction

    // Walks forward one month boundary at a time, as the block does.
    function automatic date_out_t advance_date(input logic [IN_DATA_BITS-1:0] beat);
        date_out_t   res;
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned left;
        int unsigned span;
        int unsigned ymax;
        d    = beat[DAY_BITS-1:0];
        m    = beat[MONTH_LO +: MONTH_BITS];
        y    = beat[YEAR_LO +: YEAR_BITS];
        left = beat[COUNT_LO +: COUNT_BITS];
        ymax = YEAR_MAX;
        res.src   = beat;
        res.valid = 1'b0;
        res.ovf   = 1'b0;
        if (m >= MONTH_JAN && m <= MONTH_DEC && y >= 1 && d >= FIRST_DAY
                && d <= days_in_month(m, y)) begin
            res.valid = 1'b1;
            while (left > 0) begin
                span = days_in_month(m, y) - d + 1;
                if (left < span) begin
                    d    = d + left;
                    left = 0;
                end else if (m == MONTH_DEC && y == ymax) begin
                    // Running past the last day of the largest year stops there.
                    d       = DAYS_31;
                    res.ovf = 1'b1;
                    left    = 0;
                end else begin
                    left = left - span;
                    d    = FIRST_DAY;
                    if (m == MONTH_DEC) begin
                        m = MONTH_JAN;
                        y = y + 1;
                    end else begin
                        m = m + 1;
                    end
                end
            end
        end
        res.day   = DAY_BITS'(d);
        res.month = MONTH_BITS'(m);
        res.year  = YEAR_BITS'(y);
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_dates.delete();
            pending = 0;
        end else begin
            // The result side is handled first so that a beat never matches
            // an input accepted at the same edge.
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_dates.size() == 0) begin
                    report($sformatf("result beat %h/%b with no input pending",
                                     m_axis_tdata, m_axis_tuser));
                end else begin
                    want = expected_dates.pop_front();
                    if (m_axis_tdata[DAY_BITS-1:0] !== want.day)
                        report($sformatf("in %h: end_day %0d, want %0d", want.src,
                                         m_axis_tdata[DAY_BITS-1:0], want.day));
                    if (m_axis_tdata[MONTH_LO +: MONTH_BITS] !== want.month)
                        report($sformatf("in %h: end_month %0d, want %0d", want.src,
                                         m_axis_tdata[MONTH_LO +: MONTH_BITS], want.month));
                    if (m_axis_tdata[YEAR_LO +: YEAR_BITS] !== want.year)
                        report($sformatf("in %h: end_year %0d, want %0d", want.src,
                                         m_axis_tdata[YEAR_LO +: YEAR_BITS], want.year));
                    if (m_axis_tuser[0] !== want.valid)
                        report($sformatf("in %h: date_valid %b, want %b", want.src,
                                         m_axis_tuser[0], want.valid));
                    if (m_axis_tuser[1] !== want.ovf)
                        report($sformatf("in %h: year_overflow %b, want %b", want.src,
                                         m_axis_tuser[1], want.ovf));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_dates = {expected_dates, advance_date(s_axis_tdata)};
            end
            if (end_check && !leftover_reported && expected_dates.size() != 0) begin
                report($sformatf("%0d results never arrived", expected_dates.size()));
                leftover_reported = 1'b1;
            end
            pending = expected_dates.size();
        end
    end

endmodule

// ===== tb/tb_calendar_date_advance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_date_advance
// Stream stimulus and verdict for the calendar date advance unit.
// ----------------------------------------------------------------------------
// A directed set of calendar corner cases is followed by random dates, most
// of them plausible and some raw field noise. Both channels idle at random,
// and once the result side holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_calendar_date_advance;
    import cda_pkg::*;

    localparam int  RESET_CYCLES = 12;
    localparam int  RANDOM_ITEMS = 75;
    localparam int  LONG_HOLD    = 4000;
    localparam int  DRAIN_LIMIT  = 200000;
    localparam int  TAIL_CYCLES  = 3000;
    localparam longint WATCHDOG_NS = 64'd14_400_000;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
    logic                     m_axis_tready = 1'b0;
    logic                     end_check     = 1'b0;
    bit                       hold_request  = 1'b0;
    wire logic                s_axis_tready;
    wire logic                m_axis_tvalid;
    wire logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    wire logic [OUT_USER_BITS-1:0] m_axis_tuser;
    int                       fail_count;
    int                       pending;

    always #6 aclk = ~aclk;

    calendar_date_advance u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cda_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .end_check     (end_check),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Called at a falling edge; returns at a falling edge.
    task automatic send_date(input int unsigned day, input int unsigned month,
                             input int unsigned year, input int unsigned count);
        logic [IN_DATA_BITS-1:0] beat;
        int unsigned             gap;
        beat = '0;
        beat[DAY_BITS-1:0]            = DAY_BITS'(day);
        beat[MONTH_LO +: MONTH_BITS]  = MONTH_BITS'(month);
        beat[YEAR_LO +: YEAR_BITS]    = YEAR_BITS'(year);
        beat[COUNT_LO +: COUNT_BITS]  = COUNT_BITS'(count);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_random_date();
        int unsigned r;
        int unsigned day;
        int unsigned month;
        int unsigned year;
        int unsigned count;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            month = $urandom_range(MONTH_JAN, MONTH_DEC);
            case ($urandom_range(0, 3))
                0: begin year = $urandom_range(1, YEAR_MAX); end
                1: begin year = $urandom_range(YEAR_MAX - 83, YEAR_MAX); end
                2: begin year = 100 * $urandom_range(1, 163); end
                default: begin year = $urandom_range(1, 3000); end
            endcase
            // Days past the 28th probe month lengths and the leap rule.
            day = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 28) : $urandom_range(29, 31);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin count = $urandom_range(0, 40); end
                4, 5, 6:    begin count = $urandom_range(0, 800); end
                7, 8:       begin count = $urandom & 16'hFFFF; end
                default:    begin count = 16'hFFFF - $urandom_range(0, 15); end
            endcase
        end else begin
            day   = $urandom_range(0, 31);
            month = $urandom_range(0, 15);
            year  = $urandom_range(0, YEAR_MAX);
            count = $urandom & 16'hFFFF;
        end
        send_date(day, month, year, count);
    endtask

    // Result side: random ready pattern plus one long hold-off.
    initial begin
        int unsigned run;
        int unsigned stall;
        int unsigned r;
        bit          hold_done;
        hold_done = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_request && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_done = 1'b1;
            end
            m_axis_tready <= 1'b1;
            run = ($urandom_range(0, 99) < 20) ? $urandom_range(50, 300) : $urandom_range(1, 8);
            repeat (run) @(negedge aclk);
            r = $urandom_range(0, 99);
            stall = (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(20, 80);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    initial begin
        #(WATCHDOG_NS);
        $display("tb_calendar_date_advance NOT OK");
        $finish;
    end

    initial begin
        int waited;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_date(31, MONTH_DEC, 2023, 1);
        send_date(28, MONTH_FEB, 2024, 1);
        send_date(28, MONTH_FEB, 1900, 1);
        send_date(28, MONTH_FEB, 2000, 1);
        send_date(29, MONTH_FEB, 2023, 5);
        send_date(29, MONTH_FEB, 2000, 0);
        send_date(29, MONTH_FEB, 1900, 0);
        send_date(1, 0, 2020, 10);
        send_date(1, 13, 2020, 10);
        send_date(15, 15, YEAR_MAX, 16'hFFFF);
        send_date(10, MONTH_JUN, 0, 3);
        send_date(0, 5, 2021, 3);
        send_date(31, MONTH_APR, 2021, 1);
        send_date(31, MONTH_JAN, 2021, 28);
        send_date(30, MONTH_NOV, 2021, 1);
        send_date(31, MONTH_DEC, YEAR_MAX, 1);
        send_date(1, MONTH_JAN, YEAR_MAX, 16'hFFFF);
        send_date(1, MONTH_JAN, 1, 16'hFFFF);
        send_date(1, MONTH_JAN, YEAR_MAX - 133, 16'hFFFF);
        send_date(31, MONTH_DEC, YEAR_MAX - 1, 365);
        send_date(31, MONTH_DEC, YEAR_MAX - 1, 366);
        send_date(0, 0, 0, 0);
        send_date(31, 15, YEAR_MAX, 16'hFFFF);
        send_date(1, 3, 2024, 16'hFFFF);
        send_date(15, MONTH_JUN, 2020, 0);

        hold_request = 1'b1;
        repeat (RANDOM_ITEMS) send_random_date();
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (pending != 0) begin
            $display("tb_calendar_date_advance NOT OK");
            $finish;
        end else begin
            repeat (TAIL_CYCLES) @(negedge aclk);
            end_check <= 1'b1;
            repeat (2) @(negedge aclk);
            if (fail_count == 0) begin
                $display("tb_calendar_date_advance OK");
            end else begin
                $display("tb_calendar_date_advance NOT OK");
            end
            $finish;
        end
    end

endmodule
